### rtl/agm_pkg.sv
// ----------------------------------------------------------------------------
// agm_pkg
// Shared types and constants for the gain, gate and level meter block.
// ----------------------------------------------------------------------------
package agm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 9;
  localparam int THRESH_W = 16;
  localparam int HANG_W   = 8;
  localparam int LEVEL_W  = 17;
  localparam int AVG_W    = 17;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [GAIN_W-1:0]  UNITY_GAIN = 9'd256;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 17'd65536;
  localparam logic [7:0]         KEEP_COEF  = 8'd179;
  localparam logic [7:0]         NEW_COEF   = 8'd230;

  // register reset values
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 9'd205;
  localparam logic                MUTED_RST  = 1'b0;
  localparam logic [THRESH_W-1:0] THRESH_RST = 16'd24;
  localparam logic [HANG_W-1:0]   HANG_RST   = 8'd12;

  // register index (word address)
  localparam logic [1:0] REG_GAIN   = 2'd0;
  localparam logic [1:0] REG_MUTED  = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;
  localparam logic [1:0] REG_HANG   = 2'd3;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain;
    logic                muted;
    logic [THRESH_W-1:0] peak_threshold;
    logic [HANG_W-1:0]   hangover_blocks;
  } agm_cfg_t;

  // per-beat block status out of the statistics stage
  typedef struct packed {
    logic done;
    logic live;
  } agm_blk_t;

endpackage

### rtl/audio_gain_gate_level_meter.sv
// ----------------------------------------------------------------------------
// audio_gain_gate_level_meter
// Q8 gain with mute, block noise gate with hangover, smoothed level meter.
// ----------------------------------------------------------------------------
// pipeline: input, stats, gate/mult and level registers, in that order
// throughput: one beat per cycle; each stage moves when the next one has room
// the level average uses one reciprocal multiply per beat in the gate stage
// reset: pipeline empty, block counters, hangover and level cleared, amp off,
// registers back to gain 205, unmuted, threshold 24, hangover 12
// ----------------------------------------------------------------------------
module audio_gain_gate_level_meter #(
  parameter int BLOCK_LEN = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [agm_pkg::SAMPLE_W-1:0] in_sample_in,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [agm_pkg::SAMPLE_W-1:0] out_left_out,
  output logic signed [agm_pkg::SAMPLE_W-1:0] out_right_out,
  output logic                                out_block_done,
  output logic                                out_amp_enable,
  output logic        [agm_pkg::LEVEL_W-1:0]  out_level_out,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [agm_pkg::PADDR_W-1:0]  paddr,
  input  logic        [agm_pkg::PDATA_W-1:0]  pwdata,
  output logic        [agm_pkg::PDATA_W-1:0]  prdata,
  output logic                                pready
);

  localparam int SUM_W = $clog2(BLOCK_LEN) + 16;

  agm_pkg::agm_cfg_t cfg;

  // stage valids and advance chain
  logic a_vld_r, b_vld_r, c_vld_r, out_vld_r;
  logic adv_b, adv_c, adv_d;

  logic signed [agm_pkg::SAMPLE_W-1:0] a_sample_r;
  logic signed [agm_pkg::SAMPLE_W-1:0] scaled;
  logic signed [agm_pkg::SAMPLE_W-1:0] b_v_r, c_v_r, out_v_r;
  agm_pkg::agm_blk_t                   blk;
  logic [SUM_W-1:0]                    sum_end;
  logic                                c_done_r, out_done_r;

  logic [agm_pkg::HANG_W-1:0] hang_r, hang_nxt;
  logic                       amp_r, amp_nxt, out_amp_r;
  logic [agm_pkg::LEVEL_W-1:0] level;

  assign adv_d    = !out_vld_r || !out_stall;
  assign adv_c    = !c_vld_r || adv_d;
  assign adv_b    = !b_vld_r || adv_c;
  assign in_stall = a_vld_r && !adv_b;

  agm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (!in_stall) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_sample_r <= in_sample_in;
    end
  end

  // stats stage
  agm_gain_scale u_scale (
    .sample (a_sample_r),
    .gain   (cfg.gain),
    .muted  (cfg.muted),
    .scaled (scaled)
  );

  agm_block_stats #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_stats (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (a_vld_r && adv_b),
    .sample  (a_sample_r),
    .cfg     (cfg),
    .blk     (blk),
    .sum_end (sum_end)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv_b) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_vld_r && adv_b) begin
      b_v_r <= scaled;
    end
  end

  // gate stage: hangover counter and amp enable
  always_comb begin
    hang_nxt = hang_r;
    amp_nxt  = amp_r;
    if (blk.done) begin
      if (blk.live) begin
        hang_nxt = cfg.hangover_blocks;
      end else if (hang_r != '0) begin
        hang_nxt = hang_r - agm_pkg::HANG_W'(1);
      end
      amp_nxt = blk.live || (hang_nxt != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
      hang_r  <= '0;
      amp_r   <= 1'b0;
    end else if (adv_c) begin
      c_vld_r <= b_vld_r;
      if (b_vld_r) begin
        hang_r <= hang_nxt;
        amp_r  <= amp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_vld_r && adv_c) begin
      c_v_r    <= b_v_r;
      c_done_r <= blk.done;
    end
  end

  // multiply in the gate stage, level update into the result register
  agm_level_meter #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_level (
    .clk      (clk),
    .rst_n    (rst_n),
    .mul_load (b_vld_r && adv_c),
    .sum_end  (sum_end),
    .upd_load (c_vld_r && adv_d),
    .upd_done (c_done_r),
    .level    (level)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv_d) begin
      out_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_vld_r && adv_d) begin
      out_v_r    <= c_v_r;
      out_done_r <= c_done_r;
      out_amp_r  <= amp_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_left_out   = out_v_r;
  assign out_right_out  = out_v_r;
  assign out_block_done = out_done_r;
  assign out_amp_enable = out_amp_r;
  assign out_level_out  = level;

  // a running hangover always keeps the amplifier on
  a_hang_amp: assert property (@(posedge clk) disable iff (!rst_n)
    (hang_r != '0) |-> amp_r)
    else $error("hangover running with amp off");

  // smoothed level never passes full scale
  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    level <= agm_pkg::LEVEL_ONE)
    else $error("level above full scale");

  // input only backs up when the input register and every later stage are holding a beat
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (a_vld_r && b_vld_r && c_vld_r && out_vld_r))
    else $error("input stalled with room in pipeline");

  // level only moves on a block end leaving the pipeline
  a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(c_vld_r && adv_d && c_done_r) |=> $stable(level))
    else $error("level changed outside block end");

endmodule

### rtl/agm_cfg_regs.sv
// ----------------------------------------------------------------------------
// agm_cfg_regs
// APB register file: gain, mute, peak threshold and hangover length.
// ----------------------------------------------------------------------------
module agm_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [agm_pkg::PADDR_W-1:0]  paddr,
  input  logic [agm_pkg::PDATA_W-1:0]  pwdata,
  output logic [agm_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output agm_pkg::agm_cfg_t            cfg
);

  agm_pkg::agm_cfg_t cfg_r;
  logic [1:0]        reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain            <= agm_pkg::GAIN_RST;
      cfg_r.muted           <= agm_pkg::MUTED_RST;
      cfg_r.peak_threshold  <= agm_pkg::THRESH_RST;
      cfg_r.hangover_blocks <= agm_pkg::HANG_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        agm_pkg::REG_GAIN:   cfg_r.gain            <= pwdata[agm_pkg::GAIN_W-1:0];
        agm_pkg::REG_MUTED:  cfg_r.muted           <= pwdata[0];
        agm_pkg::REG_THRESH: cfg_r.peak_threshold  <= pwdata[agm_pkg::THRESH_W-1:0];
        agm_pkg::REG_HANG:   cfg_r.hangover_blocks <= pwdata[agm_pkg::HANG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      agm_pkg::REG_GAIN:   prdata = 32'(cfg_r.gain);
      agm_pkg::REG_MUTED:  prdata = 32'(cfg_r.muted);
      agm_pkg::REG_THRESH: prdata = 32'(cfg_r.peak_threshold);
      agm_pkg::REG_HANG:   prdata = 32'(cfg_r.hangover_blocks);
      default:             prdata = '0;
    endcase
  end

endmodule

### rtl/agm_gain_scale.sv
// ----------------------------------------------------------------------------
// agm_gain_scale
// Q8 gain multiply, truncation toward zero, 16-bit saturation and mute.
// ----------------------------------------------------------------------------
module agm_gain_scale (
  input  logic signed [agm_pkg::SAMPLE_W-1:0] sample,
  input  logic        [agm_pkg::GAIN_W-1:0]   gain,
  input  logic                                muted,
  output logic signed [agm_pkg::SAMPLE_W-1:0] scaled
);

  localparam logic signed [17:0] SAT_MAX = 18'sd32767;
  localparam logic signed [17:0] SAT_MIN = -18'sd32768;

  logic        [agm_pkg::GAIN_W-1:0] gain_lim;
  logic signed [25:0]                prod;
  logic signed [17:0]                quo;

  always_comb begin
    gain_lim = (gain > agm_pkg::UNITY_GAIN) ? agm_pkg::UNITY_GAIN : gain;
    prod     = sample * $signed({1'b0, gain_lim});
    quo      = prod[25:8];
    // arithmetic shift rounds down, nudge negatives back toward zero
    if (prod[25] && (prod[7:0] != 8'd0)) begin
      quo = quo + 18'sd1;
    end
    if (muted) begin
      scaled = '0;
    end else if (quo > SAT_MAX) begin
      scaled = SAT_MAX[15:0];
    end else if (quo < SAT_MIN) begin
      scaled = SAT_MIN[15:0];
    end else begin
      scaled = quo[15:0];
    end
  end

endmodule

### rtl/agm_block_stats.sv
// ----------------------------------------------------------------------------
// agm_block_stats
// Per-block peak and magnitude sum, block position and live detection.
// ----------------------------------------------------------------------------
module agm_block_stats #(
  parameter int BLOCK_LEN = 128
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       load,
  input  logic signed [agm_pkg::SAMPLE_W-1:0]        sample,
  input  agm_pkg::agm_cfg_t                          cfg,
  output agm_pkg::agm_blk_t                          blk,
  output logic        [$clog2(BLOCK_LEN)+15:0]       sum_end
);

  localparam int IDX_W = $clog2(BLOCK_LEN);
  localparam int SUM_W = IDX_W + 16;

  logic [IDX_W-1:0]             idx_r;
  logic [agm_pkg::SAMPLE_W-1:0] peak_r;
  logic [SUM_W-1:0]             sum_r;
  agm_pkg::agm_blk_t            blk_r;
  logic [SUM_W-1:0]             sum_end_r;

  logic [agm_pkg::SAMPLE_W-1:0] mag;
  logic [agm_pkg::SAMPLE_W-1:0] peak_nxt;
  logic [SUM_W-1:0]             sum_nxt;
  logic                         last;

  always_comb begin
    // -32768 comes out as 0x8000, which is the right unsigned magnitude
    mag      = sample[agm_pkg::SAMPLE_W-1] ? 16'(-sample) : 16'(sample);
    peak_nxt = (mag > peak_r) ? mag : peak_r;
    sum_nxt  = sum_r + SUM_W'(mag);
    last     = (idx_r == IDX_W'(BLOCK_LEN - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      peak_r <= '0;
      sum_r  <= '0;
    end else if (load) begin
      if (last) begin
        idx_r  <= '0;
        peak_r <= '0;
        sum_r  <= '0;
      end else begin
        idx_r  <= idx_r + IDX_W'(1);
        peak_r <= peak_nxt;
        sum_r  <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      blk_r.done <= last;
      blk_r.live <= !cfg.muted && (peak_nxt > cfg.peak_threshold);
      sum_end_r  <= sum_nxt;
    end
  end

  assign blk     = blk_r;
  assign sum_end = sum_end_r;

endmodule

### rtl/agm_level_meter.sv
// ----------------------------------------------------------------------------
// agm_level_meter
// Block average by reciprocal multiply, then the smoothed level update.
// ----------------------------------------------------------------------------
module agm_level_meter #(
  parameter int BLOCK_LEN = 128
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 mul_load,
  input  logic [$clog2(BLOCK_LEN)+15:0]        sum_end,
  input  logic                                 upd_load,
  input  logic                                 upd_done,
  output logic [agm_pkg::LEVEL_W-1:0]          level
);

  localparam int IDX_W = $clog2(BLOCK_LEN);
  localparam int SUM_W = IDX_W + 16;
  localparam int NUM_W = SUM_W + 1;
  localparam int SHIFT = NUM_W + IDX_W;
  localparam int REC_W = NUM_W + 1;
  localparam int PRD_W = NUM_W + REC_W;
  // floor(2^SHIFT / BLOCK_LEN) + 1 gives an exact quotient for any NUM_W-bit numerator
  localparam logic [63:0] RECIP = ((64'd1 << SHIFT) / 64'(BLOCK_LEN)) + 64'd1;
  localparam logic [REC_W-1:0] RECIP_M = RECIP[REC_W-1:0];

  logic [PRD_W-1:0]            prod_r;
  logic [agm_pkg::LEVEL_W-1:0] level_r;
  logic [agm_pkg::LEVEL_W-1:0] level_nxt;
  logic [NUM_W-1:0]            num;
  logic [agm_pkg::AVG_W-1:0]   avg2;
  logic [25:0]                 mix;

  assign num = {sum_end, 1'b0};

  always_ff @(posedge clk) begin
    if (mul_load) begin
      prod_r <= PRD_W'(num) * PRD_W'(RECIP_M);
    end
  end

  always_comb begin
    avg2 = prod_r[SHIFT +: agm_pkg::AVG_W];
    mix  = 26'(level_r) * 26'(agm_pkg::KEEP_COEF) + 26'(avg2) * 26'(agm_pkg::NEW_COEF);
    level_nxt = (mix[25:8] > 18'(agm_pkg::LEVEL_ONE)) ? agm_pkg::LEVEL_ONE : mix[24:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else if (upd_load && upd_done) begin
      level_r <= level_nxt;
    end
  end

  assign level = level_r;

endmodule
